// File: hw/rtl/bmc_pkg.sv
// Shared types and constants for the byte-wise modular exponentiation cipher.
// No dependencies; imported by the channel interfaces and the top level.
package bmc_pkg;

  localparam int BYTE_W      = 8;
  localparam int GROUP_BYTES = 8;
  localparam int GROUP_W     = BYTE_W * GROUP_BYTES;
  localparam int EXP_W       = 32;
  localparam int MOD_REG_W   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int HELD_W      = $clog2(GROUP_BYTES);
  localparam int OCNT_W      = $clog2(GROUP_BYTES) + 1;
  localparam int EBIT_W      = $clog2(EXP_W);
  localparam int CNT_W       = $clog2(GROUP_W);
  localparam int MIN_MODULUS = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_MODULUS = 2'd1,
    ERR_GROUP   = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_EBIT,
    S_MULR,
    S_SQR,
    S_DONE
  } state_e;

endpackage

// File: hw/rtl/bmc_in_if.sv
// Input channel: one byte per beat with an end-of-message flag.
// Depends on bmc_pkg for the byte width.
interface bmc_in_if import bmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;

  modport source(output valid, output data_byte, output end_of_message, input ready);
  modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

// File: hw/rtl/bmc_out_if.sv
// Output channel: one result byte per beat with last marker and error code.
// Depends on bmc_pkg for the byte width.
interface bmc_out_if import bmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [1:0]        error;

  modport source(output valid, output out_byte, output last_of_run, output error, input ready);
  modport sink(input valid, input out_byte, input last_of_run, input error, output ready);
endinterface

// File: hw/rtl/bytewise_modexp_cipher.sv
// Top level of the byte-wise modular exponentiation cipher.
// Depends on bmc_pkg, bmc_in_if and bmc_out_if.
//
// Usage:
//   Configure mode, exponent and modulus through the write port (cfg_we_i,
//   cfg_idx_i, cfg_wdata_i) while the block is idle. Feed bytes on byte_in;
//   results leave on byte_out. Encrypt: each byte gives eight big-endian
//   result beats, the eighth marked last. Decrypt: every eighth byte gives
//   one result beat; an earlier end-of-message gives one error beat.
//   A bad modulus (256 or less) gives one error beat per encrypt byte or
//   completed decrypt group.
// Operation, with NW = min(MOD_BITS, 32): for each of the 32 exponent bits,
//   from the lowest up, the result is multiplied by the base if the bit is set
//   and the base is then squared; decrypt first reduces the group bit by bit. All
//   work runs on one shared bit-serial modular multiplier that steps through the
//   NW multiplier bits, one bit per cycle, so one item occupies the block until done.
//   Partial decrypt bytes and error cases skip the multiplier.
// byte_in.ready is high only between items. Results sit in an output buffer,
//   so the next item is accepted and computed while the receiver stalls.
// Reset: mode encrypt, exponent 3, modulus 0, decrypt group empty.
module bytewise_modexp_cipher import bmc_pkg::*; #(
  parameter int MOD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bmc_in_if.sink                byte_in,
  bmc_out_if.source             byte_out
);

  localparam int NW = (MOD_BITS < MOD_REG_W) ? MOD_BITS : MOD_REG_W;

  state_e               state_q, state_d;
  logic                 mode_q;
  logic [EXP_W-1:0]     exp_cfg_q;
  logic [MOD_REG_W-1:0] modulus_q;
  logic [GROUP_W-1:0]   gv_q, gv_d;
  logic [HELD_W-1:0]    held_q, held_d;
  logic [GROUP_W-1:0]   red_v_q, red_v_d;
  logic [NW-1:0]        result_q, result_d;
  logic [NW-1:0]        base_q, base_d;
  logic [NW-1:0]        ma_q, ma_d;
  logic [NW-1:0]        mb_q, mb_d;
  logic [NW-1:0]        acc_q, acc_d;
  logic [EXP_W-1:0]     exp_q, exp_d;
  logic [EBIT_W-1:0]    ebit_q, ebit_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  err_e                 perr_q, perr_d;
  logic [GROUP_W-1:0]   obuf_q, obuf_d;
  logic [OCNT_W-1:0]    ocnt_q, ocnt_d;
  err_e                 oerr_q, oerr_d;
  logic                 ovalid_q, ovalid_d;

  logic [NW-1:0]        n_w;
  logic                 bad;
  logic                 in_beat;
  logic                 out_beat;
  logic [GROUP_W-1:0]   gv_next;
  logic [NW:0]          red_t;
  logic [NW-1:0]        red_r;
  logic [NW:0]          sum_acc;
  logic [NW-1:0]        acc_add;
  logic [NW:0]          sum_dbl;
  logic [NW-1:0]        ma_dbl;
  logic [NW-1:0]        acc_step;
  logic                 mul_last;

  assign n_w      = modulus_q[NW-1:0];
  assign bad      = (n_w <= NW'(MIN_MODULUS));
  assign in_beat  = byte_in.valid && byte_in.ready;
  assign out_beat = ovalid_q && byte_out.ready;
  assign gv_next  = {gv_q[GROUP_W-BYTE_W-1:0], byte_in.data_byte};

  assign red_t = {base_q, red_v_q[GROUP_W-1]};
  assign red_r = (red_t >= {1'b0, n_w}) ? NW'(red_t - {1'b0, n_w}) : red_t[NW-1:0];

  assign sum_acc  = {1'b0, acc_q} + {1'b0, ma_q};
  assign acc_add  = (sum_acc >= {1'b0, n_w}) ? NW'(sum_acc - {1'b0, n_w}) : sum_acc[NW-1:0];
  assign sum_dbl  = {1'b0, ma_q} + {1'b0, ma_q};
  assign ma_dbl   = (sum_dbl >= {1'b0, n_w}) ? NW'(sum_dbl - {1'b0, n_w}) : sum_dbl[NW-1:0];
  assign acc_step = mb_q[0] ? acc_add : acc_q;
  assign mul_last = (cnt_q == CNT_W'(NW - 1));

  assign byte_in.ready        = (state_q == S_IDLE);
  assign byte_out.valid       = ovalid_q;
  assign byte_out.out_byte    = obuf_q[GROUP_W-1 -: BYTE_W];
  assign byte_out.last_of_run = (ocnt_q == OCNT_W'(1));
  assign byte_out.error       = oerr_q;

  always_comb begin
    state_d  = state_q;
    gv_d     = gv_q;
    held_d   = held_q;
    red_v_d  = red_v_q;
    result_d = result_q;
    base_d   = base_q;
    ma_d     = ma_q;
    mb_d     = mb_q;
    acc_d    = acc_q;
    exp_d    = exp_q;
    ebit_d   = ebit_q;
    cnt_d    = cnt_q;
    perr_d   = perr_q;
    obuf_d   = obuf_q;
    ocnt_d   = ocnt_q;
    oerr_d   = oerr_q;
    ovalid_d = ovalid_q;

    // drain the output buffer one byte per beat
    if (out_beat) begin
      obuf_d = {obuf_q[GROUP_W-BYTE_W-1:0], BYTE_W'(0)};
      ocnt_d = ocnt_q - OCNT_W'(1);
      if (ocnt_q == OCNT_W'(1)) begin
        ovalid_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (mode_q == MODE_ENCRYPT) begin
            if (bad) begin
              perr_d  = ERR_MODULUS;
              state_d = S_DONE;
            end else begin
              perr_d   = ERR_OK;
              base_d   = NW'(byte_in.data_byte);
              result_d = NW'(1);
              exp_d    = exp_cfg_q;
              ebit_d   = '0;
              state_d  = S_EBIT;
            end
          end else if (held_q != HELD_W'(GROUP_BYTES - 1)) begin
            if (byte_in.end_of_message) begin
              gv_d    = '0;
              held_d  = '0;
              perr_d  = ERR_GROUP;
              state_d = S_DONE;
            end else begin
              gv_d   = gv_next;
              held_d = held_q + HELD_W'(1);
            end
          end else begin
            gv_d   = '0;
            held_d = '0;
            if (bad) begin
              perr_d  = ERR_MODULUS;
              state_d = S_DONE;
            end else begin
              perr_d  = ERR_OK;
              red_v_d = gv_next;
              base_d  = '0;
              cnt_d   = '0;
              state_d = S_RED;
            end
          end
        end
      end
      S_RED: begin
        base_d  = red_r;
        red_v_d = {red_v_q[GROUP_W-2:0], 1'b0};
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(GROUP_W - 1)) begin
          result_d = NW'(1);
          exp_d    = exp_cfg_q;
          ebit_d   = '0;
          state_d  = S_EBIT;
        end
      end
      S_EBIT: begin
        cnt_d = '0;
        acc_d = '0;
        if (exp_q[0]) begin
          ma_d    = result_q;
          mb_d    = base_q;
          state_d = S_MULR;
        end else begin
          ma_d    = base_q;
          mb_d    = base_q;
          state_d = S_SQR;
        end
      end
      S_MULR: begin
        acc_d = acc_step;
        ma_d  = ma_dbl;
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (mul_last) begin
          result_d = acc_step;
          ma_d     = base_q;
          mb_d     = base_q;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = S_SQR;
        end
      end
      S_SQR: begin
        acc_d = acc_step;
        ma_d  = ma_dbl;
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (mul_last) begin
          base_d = acc_step;
          exp_d  = exp_q >> 1;
          ebit_d = ebit_q + EBIT_W'(1);
          if (ebit_q == EBIT_W'(EXP_W - 1)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_EBIT;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          oerr_d   = perr_q;
          if (perr_q != ERR_OK) begin
            obuf_d = '0;
            ocnt_d = OCNT_W'(1);
          end else if (mode_q == MODE_ENCRYPT) begin
            obuf_d = GROUP_W'(result_q);
            ocnt_d = OCNT_W'(GROUP_BYTES);
          end else begin
            obuf_d = {result_q[BYTE_W-1:0], (GROUP_W - BYTE_W)'(0)};
            ocnt_d = OCNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_ENCRYPT;
      exp_cfg_q <= EXP_W'(3);
      modulus_q <= '0;
      gv_q      <= '0;
      held_q    <= '0;
      ocnt_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      gv_q     <= gv_d;
      held_q   <= held_d;
      ocnt_q   <= ocnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:     mode_q    <= cfg_wdata_i[0];
          CFG_EXPONENT: exp_cfg_q <= cfg_wdata_i[EXP_W-1:0];
          CFG_MODULUS:  modulus_q <= cfg_wdata_i[MOD_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_v_q  <= red_v_d;
    result_q <= result_d;
    base_q   <= base_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    acc_q    <= acc_d;
    exp_q    <= exp_d;
    ebit_q   <= ebit_d;
    cnt_q    <= cnt_d;
    perr_q   <= perr_d;
    obuf_q   <= obuf_d;
    oerr_q   <= oerr_d;
  end

  a_ovalid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (ocnt_q != '0) && (ocnt_q <= OCNT_W'(GROUP_BYTES)))
    else $error("output buffer valid with bad count");

  a_group_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (mode_q != MODE_ENCRYPT) && (held_q == HELD_W'(GROUP_BYTES - 1)))
      |=> (held_q == '0) && (gv_q == '0))
    else $error("decrypt group not cleared after eighth byte");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && (oerr_q != ERR_OK))
      |-> (ocnt_q == OCNT_W'(1)) && (obuf_q[GROUP_W-1 -: BYTE_W] == '0))
    else $error("error result not a single zero byte");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !ovalid_q) |=> ovalid_q && (state_q == S_IDLE))
    else $error("finished item not loaded into output buffer");

endmodule

// File: dv/tb_bytewise_modexp_cipher.sv
// Self-checking testbench for bytewise_modexp_cipher: byte items in, result beats out.
// It predicts each beat from its own modular exponentiation of the configured state.
// Depends on bmc_pkg, bmc_in_if, bmc_out_if and the top level RTL.
module tb_bytewise_modexp_cipher;
  import bmc_pkg::*;

  localparam logic                 MODE_DECRYPT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int FEED_TOTAL   = 290;
  localparam int DRAIN_CYCLES = 32;
  localparam int TAIL_CYCLES  = 2200;
  localparam int RUN_LIMIT    = 20_000_000;

  typedef struct packed {
    logic              eom;
    logic [BYTE_W-1:0] data;
  } feed_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [1:0]        error;
  } rsa_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bmc_in_if  byte_in();
  bmc_out_if byte_out();

  bytewise_modexp_cipher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_in     (byte_in),
    .byte_out    (byte_out)
  );

  always #2 clk_i = ~clk_i;

  feed_item_t byte_feed[$];
  rsa_beat_t  rsa_due[$];
  int         fail_count = 0;
  int         queued = 0;
  int         feed_gap = 0;
  int         sink_left = 0;
  bit         calm = 1'b0;
  logic       in_taken;

  logic                 cfg_mode;
  logic [EXP_W-1:0]     cfg_exponent;
  logic [MOD_REG_W-1:0] cfg_modulus;
  logic [GROUP_W-1:0]   grp_value;
  int                   grp_held;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [63:0] modexp(input logic [63:0] base, input logic [EXP_W-1:0] e,
                                         input logic [63:0] n);
    logic [63:0] acc;
    acc = 64'd1 % n;
    base = base % n;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = (acc * base) % n;
      base = (base * base) % n;
    end
    return acc;
  endfunction

  task automatic due_beat(input logic [BYTE_W-1:0] ob, input logic last, input err_e err);
    rsa_beat_t beat;
    beat = {ob, last, err};
    rsa_due = {rsa_due, beat};
  endtask

  task automatic predict_beats(input logic [BYTE_W-1:0] b, input logic eom);
    logic [63:0] c;
    logic        bad;
    bad = cfg_modulus <= MIN_MODULUS;
    if (cfg_mode == MODE_ENCRYPT) begin
      if (bad) begin
        due_beat(8'h00, 1'b1, ERR_MODULUS);
      end else begin
        c = modexp({56'd0, b}, cfg_exponent, {32'd0, cfg_modulus});
        for (int i = 0; i < GROUP_BYTES; i++)
          due_beat(c[(GROUP_BYTES-1-i)*BYTE_W +: BYTE_W], i == GROUP_BYTES-1, ERR_OK);
      end
    end else begin
      grp_value = {grp_value[GROUP_W-BYTE_W-1:0], b};
      if (grp_held < GROUP_BYTES-1) begin
        grp_held++;
        if (eom) begin
          grp_value = '0;
          grp_held = 0;
          due_beat(8'h00, 1'b1, ERR_GROUP);
        end
      end else begin
        c = grp_value;
        grp_value = '0;
        grp_held = 0;
        if (bad) begin
          due_beat(8'h00, 1'b1, ERR_MODULUS);
        end else begin
          c = modexp(c, cfg_exponent, {32'd0, cfg_modulus});
          due_beat(c[BYTE_W-1:0], 1'b1, ERR_OK);
        end
      end
    end
  endtask

  task automatic send(input logic [BYTE_W-1:0] b, input logic eom);
    feed_item_t item;
    item = {eom, b};
    byte_feed = {byte_feed, item};
    queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:     cfg_mode = val[0];
      CFG_EXPONENT: cfg_exponent = val;
      CFG_MODULUS:  cfg_modulus = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (byte_feed.size() != 0 || byte_in.valid || rsa_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // accept side: predict on every input beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= byte_in.valid && byte_in.ready;
      if (byte_in.valid && byte_in.ready) predict_beats(byte_in.data_byte, byte_in.end_of_message);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_in.valid <= 1'b0;
    end else if (!byte_in.valid || in_taken) begin
      if (feed_gap > 0) begin
        byte_in.valid <= 1'b0;
        feed_gap <= feed_gap - 1;
      end else if (byte_feed.size() != 0) begin
        byte_in.valid          <= 1'b1;
        byte_in.data_byte      <= byte_feed[0].data;
        byte_in.end_of_message <= byte_feed[0].eom;
        void'(byte_feed.pop_front());
        feed_gap <= pick_gap();
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_out.ready <= 1'b0;
    end else if (sink_left > 0) begin
      sink_left <= sink_left - 1;
    end else if (calm || $urandom_range(0, 1)) begin
      byte_out.ready <= 1'b1;
      sink_left <= $urandom_range(0, 15);
    end else begin
      byte_out.ready <= 1'b0;
      sink_left <= pick_gap();
    end
  end

  rsa_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && byte_out.valid && byte_out.ready) begin
      if (rsa_due.size() == 0) begin
        $display("%0t: unexpected beat byte %02h last %0d error %0d", $time,
                 byte_out.out_byte, byte_out.last_of_run, byte_out.error);
        fail_count++;
      end else begin
        want = rsa_due.pop_front();
        if (byte_out.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
                   byte_out.out_byte);
          fail_count++;
        end
        if (byte_out.last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0d got %0d", $time, want.last,
                   byte_out.last_of_run);
          fail_count++;
        end
        if (byte_out.error !== want.error) begin
          $display("%0t: error expected %0d got %0d", $time, want.error, byte_out.error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          k;
    int          zeros;
    int          r;
    logic [31:0] m;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_MODE;
    cfg_wdata_i            = '0;
    byte_in.valid          = 1'b0;
    byte_in.data_byte      = '0;
    byte_in.end_of_message = 1'b0;
    byte_out.ready         = 1'b0;
    cfg_mode               = MODE_ENCRYPT;
    cfg_exponent           = 32'd3;
    cfg_modulus            = '0;
    grp_value              = '0;
    grp_held               = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // bad modulus at reset values, then at the boundary
    send(8'h00, 1'b0);
    drain();
    write_reg(CFG_MODULUS, 32'd256);
    send(8'hFF, 1'b1);
    drain();
    write_reg(CFG_MODULUS, 32'd257);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    drain();
    write_reg(CFG_EXPONENT, 32'hFFFF_FFFF);
    write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
    send(8'hFF, 1'b0);
    drain();
    write_reg(CFG_EXPONENT, 32'd0);
    send(8'h55, 1'b0);
    drain();
    write_reg(CFG_EXPONENT, 32'd1);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    send(8'hAA, 1'b0);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
    write_reg(CFG_EXPONENT, 32'h0001_0001);
    send(8'h12, 1'b0);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    send(8'h01, 1'b1);
    // hold a partial group across an encrypt item
    repeat (3) send(8'hFF, 1'b0);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_ENCRYPT));
    send(8'h7F, 1'b1);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_DECRYPT));
    repeat (5) send(8'hFF, 1'b0);
    drain();
    write_reg(CFG_MODULUS, 32'd1);
    for (int i = 0; i < GROUP_BYTES; i++) send(BYTE_W'($urandom), i == GROUP_BYTES-1);
    send(8'h09, 1'b1);

    while (queued < FEED_TOTAL) begin
      drain();
      calm = ($urandom_range(0, 4) == 0);
      write_reg(CFG_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 5) m = 32'd0;
        else if (r < 10) m = 32'd1;
        else if (r < 13) m = 32'hFFFF_FFFF;
        else if (r < 25) m = $urandom;
        else m = $urandom & $urandom & $urandom;
        write_reg(CFG_EXPONENT, m);
      end
      if ($urandom_range(0, 2) != 0 || cfg_modulus <= MIN_MODULUS) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          m = $urandom_range(0, MIN_MODULUS);
        end else if (r < 12) begin
          m = MIN_MODULUS + 1;
        end else if (r < 16) begin
          m = 32'hFFFF_FFFF;
        end else begin
          m = $urandom;
          if (r < 40) m = m >> $urandom_range(0, 22);
          if (m <= MIN_MODULUS) m = m + MIN_MODULUS + 1;
        end
        write_reg(CFG_MODULUS, m);
      end
      if (cfg_mode == MODE_ENCRYPT) begin
        k = $urandom_range(3, 10);
        repeat (k) send(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        k = grp_held;
        if (k != 0 && $urandom_range(0, 3) != 0)
          for (int i = k; i < GROUP_BYTES; i++) send(BYTE_W'($urandom), 1'b0);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 4) != 0) begin
            zeros = ($urandom_range(0, 4) == 0) ? 4 : 0;
            for (int i = 0; i < GROUP_BYTES; i++)
              send(BYTE_W'(i < zeros ? 32'd0 : $urandom),
                   i == GROUP_BYTES-1 && $urandom_range(0, 1));
          end else begin
            k = $urandom_range(1, GROUP_BYTES-1);
            for (int i = 0; i < k; i++) send(BYTE_W'($urandom), i == k-1);
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(1, GROUP_BYTES-1);
          repeat (k) send(BYTE_W'($urandom), 1'b0);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bmc_pkg.sv
hw/rtl/bmc_in_if.sv
hw/rtl/bmc_out_if.sv
hw/rtl/bytewise_modexp_cipher.sv
dv/tb_bytewise_modexp_cipher.sv
